@@ rtl/stt_pkg.sv @@
// Shared types, constants and helpers for the software timer table.
`default_nettype none

package stt_pkg;

  localparam int TIMER_SLOTS  = 64;
  localparam int MAX_EXPIRIES = 64;

  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
  localparam int HIT_W       = $clog2(MAX_EXPIRIES + 1);
  localparam int SLOT_PORT_W = 6;
  localparam int SLOT_EXT_W  = (SLOT_W > SLOT_PORT_W) ? SLOT_W : SLOT_PORT_W;

  // command kinds
  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_DESTROY = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_STOP    = 3'd3;
  localparam logic [2:0] KIND_RESET   = 3'd4;
  localparam logic [2:0] KIND_PROCESS = 3'd5;

  // result events
  localparam logic [2:0] EV_CREATED = 3'd0;
  localparam logic [2:0] EV_FULL    = 3'd1;
  localparam logic [2:0] EV_DONE    = 3'd2;
  localparam logic [2:0] EV_EXPIRED = 3'd3;
  localparam logic [2:0] EV_NONE    = 3'd4;

  localparam logic [1:0] TYPE_PERIODIC = 2'd1;

  typedef struct packed {
    logic [63:0] deadline;
    logic [63:0] period;
    logic [1:0]  ttype;
    logic        active;
    logic        expired;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CREATE = 6'b000010,
    ST_CMD_RD = 6'b000100,
    ST_CMD_WR = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FLUSH  = 6'b100000
  } state_t;

  // low bits of a table address, as shown on the slot port
  function automatic logic [SLOT_PORT_W-1:0] to_port_slot(input logic [SLOT_W-1:0] a);
    logic [SLOT_EXT_W-1:0] e;
    e = SLOT_EXT_W'(a);
    return e[SLOT_PORT_W-1:0];
  endfunction

  // table address from the command's slot field
  function automatic logic [SLOT_W-1:0] to_addr(input logic [SLOT_PORT_W-1:0] s);
    logic [SLOT_EXT_W-1:0] e;
    e = SLOT_EXT_W'(s);
    return e[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/stt_entry_ram.sv @@
// Timer entry memory: one write port, one registered read port.
`default_nettype none

module stt_entry_ram (
  input  wire logic              clk,
  input  wire stt_pkg::ram_req_t req,
  output stt_pkg::entry_t        rd_data
);

  stt_pkg::entry_t mem [stt_pkg::TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/stt_alu.sv @@
// Shared time unit: now plus an interval, and the deadline-passed compare.
`default_nettype none

module stt_alu (
  input  wire logic [63:0] now,
  input  wire logic [63:0] addend,
  input  wire logic [63:0] deadline,
  output logic      [63:0] sum,
  output logic             due
);

  assign sum = now + addend;   // wraps mod 2^64
  assign due = (now >= deadline);

endmodule

`default_nettype wire

@@ rtl/software_timer_table.sv @@
// Top level of the software timer table: command sequencer, scan and result register.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+----------------------------
//  request  | kind timer_type timer_index first_delay period   | taken when start && !busy
//           | now                                              |
//  result   | event_res slot expiration_total last             | strobe, one cycle, no stall
//
// Create runs ST_CREATE; destroy/start/stop/reset run ST_CMD_RD then ST_CMD_WR; an
// unknown kind is dropped (no result); process runs ST_SCAN, then ST_FLUSH. The scan
// reads one entry per cycle, evaluating and writing back each in the next cycle; an
// expiry is held back one hit so the final one can carry last. Each result is
// registered. Reset (rst, synchronous) empties the table at once: reads beyond
// slots_used return zero, so no clearing pass runs. The receiver cannot stall.
`default_nettype none

module software_timer_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [1:0]  timer_type,
  input  wire logic [5:0]  timer_index,
  input  wire logic [63:0] first_delay,
  input  wire logic [63:0] period,
  input  wire logic [63:0] now,
  output logic             strobe,
  output logic [2:0]       event_res,
  output logic [5:0]       slot,
  output logic [31:0]      expiration_total,
  output logic             last
);

  localparam int SW = stt_pkg::SLOT_W;
  localparam int CW = stt_pkg::CNT_W;
  localparam int HW = stt_pkg::HIT_W;

  stt_pkg::state_t state;

  // latched request
  logic [2:0]  kind_q;
  logic [1:0]  ttype_q;
  logic [5:0]  idx_q;
  logic [63:0] delay_q;
  logic [63:0] per_q;
  logic [63:0] now_q;

  // table bookkeeping
  logic [CW-1:0] slots_used;
  logic [31:0]   exp_count;

  // scan pipeline
  logic [CW-1:0] rd_i;       // next slot to read
  logic [SW-1:0] ev_i;       // slot whose data is on rd_data
  logic          ev_valid;
  logic [HW-1:0] n_hits;
  logic          pend_valid; // held-back expiry
  logic [SW-1:0] pend_slot;

  stt_pkg::ram_req_t ram_req;
  stt_pkg::entry_t   rd_data;
  stt_pkg::entry_t   entry;   // read data, zero beyond the fill count
  logic              rd_zero;

  logic [63:0] addend;
  logic [63:0] sum;
  logic        due;

  logic        full;
  logic        in_range;
  logic        issue;
  logic        hit;
  logic        rearm;

  logic        emit;
  logic [2:0]  emit_ev;
  logic [5:0]  emit_slot;
  logic        emit_last;

  stt_entry_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  stt_alu u_alu (
    .now      (now_q),
    .addend   (addend),
    .deadline (entry.deadline),
    .sum      (sum),
    .due      (due)
  );

  assign busy     = (state != stt_pkg::ST_IDLE);
  assign entry    = rd_zero ? '0 : rd_data;
  assign full     = (slots_used >= CW'(stt_pkg::TIMER_SLOTS));
  assign in_range = (32'(idx_q) < 32'(stt_pkg::TIMER_SLOTS));
  assign issue    = (rd_i < slots_used) && (n_hits < HW'(stt_pkg::MAX_EXPIRIES));
  assign hit      = ev_valid && (n_hits < HW'(stt_pkg::MAX_EXPIRIES)) &&
                    entry.active && !entry.expired && due;
  assign rearm    = (entry.ttype == stt_pkg::TYPE_PERIODIC) && (entry.period != 64'd0);
  assign addend   = (state == stt_pkg::ST_CREATE) ? delay_q : entry.period;

  // memory requests and result forming
  always_comb begin
    ram_req   = '0;
    emit      = 1'b0;
    emit_ev   = stt_pkg::EV_DONE;
    emit_slot = '0;
    emit_last = 1'b1;
    unique case (state)
      stt_pkg::ST_IDLE: begin
      end
      stt_pkg::ST_CREATE: begin
        emit = 1'b1;
        if (full) begin
          emit_ev = stt_pkg::EV_FULL;
        end else begin
          emit_ev               = stt_pkg::EV_CREATED;
          emit_slot             = stt_pkg::to_port_slot(slots_used[SW-1:0]);
          ram_req.we            = 1'b1;
          ram_req.waddr         = slots_used[SW-1:0];
          ram_req.wdata.deadline = sum;
          ram_req.wdata.period  = per_q;
          ram_req.wdata.ttype   = ttype_q;
          ram_req.wdata.active  = 1'b1;
          ram_req.wdata.expired = 1'b0;
        end
      end
      stt_pkg::ST_CMD_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = stt_pkg::to_addr(idx_q);
      end
      stt_pkg::ST_CMD_WR: begin
        emit          = 1'b1;
        emit_ev       = stt_pkg::EV_DONE;
        emit_slot     = idx_q;
        ram_req.we    = in_range;
        ram_req.waddr = stt_pkg::to_addr(idx_q);
        ram_req.wdata = entry;
        case (kind_q)
          stt_pkg::KIND_DESTROY: begin
            ram_req.wdata.active  = 1'b0;
            ram_req.wdata.expired = 1'b0;
          end
          stt_pkg::KIND_START: begin
            ram_req.wdata.active  = 1'b1;
            ram_req.wdata.expired = 1'b0;
          end
          stt_pkg::KIND_STOP: begin
            ram_req.wdata.active = 1'b0;
          end
          default: begin   // reset: re-arm at now + stored period
            ram_req.wdata.deadline = sum;
            ram_req.wdata.expired  = 1'b0;
          end
        endcase
      end
      stt_pkg::ST_SCAN: begin
        ram_req.re    = issue;
        ram_req.raddr = rd_i[SW-1:0];
        ram_req.we    = hit;
        ram_req.waddr = ev_i;
        ram_req.wdata = entry;
        if (rearm) begin
          ram_req.wdata.deadline = sum;
        end else begin
          ram_req.wdata.expired = 1'b1;
        end
        // a new hit releases the one held back, which is then not the last
        emit      = hit && pend_valid;
        emit_ev   = stt_pkg::EV_EXPIRED;
        emit_slot = stt_pkg::to_port_slot(pend_slot);
        emit_last = 1'b0;
      end
      stt_pkg::ST_FLUSH: begin
        emit = 1'b1;
        if (pend_valid) begin
          emit_ev   = stt_pkg::EV_EXPIRED;
          emit_slot = stt_pkg::to_port_slot(pend_slot);
        end else begin
          emit_ev = stt_pkg::EV_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stt_pkg::ST_IDLE;
      slots_used <= '0;
      exp_count  <= '0;
      strobe     <= 1'b0;
      rd_i       <= '0;
      ev_valid   <= 1'b0;
      n_hits     <= '0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= emit;
      unique case (state)
        stt_pkg::ST_IDLE: begin
          if (start) begin
            case (kind) inside
              stt_pkg::KIND_CREATE: begin
                state <= stt_pkg::ST_CREATE;
              end
              stt_pkg::KIND_DESTROY, stt_pkg::KIND_START,
              stt_pkg::KIND_STOP, stt_pkg::KIND_RESET: begin
                state <= stt_pkg::ST_CMD_RD;
              end
              stt_pkg::KIND_PROCESS: begin
                state      <= stt_pkg::ST_SCAN;
                rd_i       <= '0;
                ev_valid   <= 1'b0;
                n_hits     <= '0;
                pend_valid <= 1'b0;
              end
              default: begin   // unknown kind: dropped
                state <= stt_pkg::ST_IDLE;
              end
            endcase
          end
        end
        stt_pkg::ST_CREATE: begin
          if (!full) begin
            slots_used <= slots_used + CW'(1);
          end
          state <= stt_pkg::ST_IDLE;
        end
        stt_pkg::ST_CMD_RD: begin
          state <= stt_pkg::ST_CMD_WR;
        end
        stt_pkg::ST_CMD_WR: begin
          state <= stt_pkg::ST_IDLE;
        end
        stt_pkg::ST_SCAN: begin
          ev_valid <= issue;
          if (issue) begin
            rd_i <= rd_i + CW'(1);
          end
          if (hit) begin
            exp_count  <= exp_count + 32'd1;
            n_hits     <= n_hits + HW'(1);
            pend_valid <= 1'b1;
          end
          if (!issue) begin
            state <= stt_pkg::ST_FLUSH;
          end
        end
        stt_pkg::ST_FLUSH: begin
          pend_valid <= 1'b0;
          state      <= stt_pkg::ST_IDLE;
        end
        default: begin
          state <= stt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q  <= kind;
      ttype_q <= timer_type;
      idx_q   <= timer_index;
      delay_q <= first_delay;
      per_q   <= period;
      now_q   <= now;
    end
    if (ram_req.re) begin
      rd_zero <= (CW'(ram_req.raddr) >= slots_used);
    end
    if (state == stt_pkg::ST_SCAN) begin
      ev_i <= rd_i[SW-1:0];
      if (hit) begin
        pend_slot <= ev_i;
      end
    end
    if (emit) begin
      event_res        <= emit_ev;
      slot             <= emit_slot;
      expiration_total <= exp_count;  // equals the held expiry's running count
      last             <= emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CW'(stt_pkg::TIMER_SLOTS))
    else $error("slot fill count beyond table size");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && event_res != stt_pkg::EV_EXPIRED) |-> last)
    else $error("non-expiry result without last");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == stt_pkg::ST_IDLE) |-> (!ram_req.we && !ram_req.re))
    else $error("memory access while idle");
`endif

endmodule

`default_nettype wire
